// File: rtl/ectp_pkg.sv
// Shared types and constants for the energy counter to power core.
// Used by ectp_ctrl, ectp_dp and energy_counter_to_power_core; no dependencies.

package ectp_pkg;

  // Socket count and the previous-count table built from it
  localparam int SOCKETS     = 8;
  localparam int TABLE_DEPTH = 2 * SOCKETS;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Scale constants
  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [9:0]  LIMIT_SCALE  = 10'd1000;
  localparam logic [29:0] MW_SCALE     = 30'd1000000000;

  // Quotient width: power never exceeds 10^6 mW once the limit test passes
  localparam int QUO_W = 20;
  localparam int CNT_W = $clog2(QUO_W);

  // Input commands
  localparam logic CMD_ROUND   = 1'b0;
  localparam logic CMD_READING = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_VALID   = 2'd0;
  localparam logic [1:0] ST_WARM    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_UNIT_EXP = 2'd0;
  localparam logic [1:0] REG_CORE_EN  = 2'd1;
  localparam logic [1:0] REG_MEM_EN   = 2'd2;

  // Reset values of the configuration registers
  localparam logic [4:0] UNIT_EXP_RST = 5'd16;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture the input word
    logic rd_delta;  // form counter delta, update previous count
    logic rd_mul;    // scale delta for limit test and power
    logic rd_check;  // limit test, load divider
    logic div_step;  // one quotient bit
    logic finish;    // load the result register
    logic rn_mul;    // seconds difference times 10^6
    logic rn_store;  // saturate and store interval, timestamp, round count
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_reading;  // captured word is a counter reading
    logic pass;        // reading needs the divider
    logic out_busy;    // result register still holds an untaken word
  } dp_status_t;

endpackage

// File: rtl/energy_counter_to_power_core.sv
// Top level of the energy counter to power core.
// Depends on ectp_pkg, ectp_ctrl and ectp_dp.

// Converts free-running 32-bit energy counters into average power in mW for
// a core and a memory domain per socket. A round-start word (command 0) sets
// the sampling interval from its timestamp and gives no result. A reading
// word (command 1) gives one result word; it skips the divider when no
// division is needed (warming up, disabled domain, zero delta, over the
// 1000 W limit) and otherwise runs the serial divider, which retires one
// quotient bit per cycle over 20 bits. One word is in work at a
// time; the next is taken as soon as the sequencer is idle, even while the
// previous result waits in the output register. Configuration writes are
// always ready and must only be issued while the core is idle.

module energy_counter_to_power_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         in_command,
  input  logic [31:0]  in_time_sec,
  input  logic [19:0]  in_time_usec,
  input  logic         in_domain,
  input  logic [2:0]   in_socket,
  input  logic [31:0]  in_counter,
  output logic         out_valid,
  input  logic         out_ready,
  output logic         out_domain,
  output logic [2:0]   out_socket,
  output logic [19:0]  out_power_mw,
  output logic [1:0]   out_status,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  ectp_pkg::ctrl_cmd_t   cmd;
  ectp_pkg::dp_status_t  status;

  // Sequencer
  ectp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath
  ectp_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_command   (in_command),
    .in_time_sec  (in_time_sec),
    .in_time_usec (in_time_usec),
    .in_domain    (in_domain),
    .in_socket    (in_socket),
    .in_counter   (in_counter),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_domain   (out_domain),
    .out_socket   (out_socket),
    .out_power_mw (out_power_mw),
    .out_status   (out_status)
  );

endmodule

// File: rtl/ectp_ctrl.sv
// Sequencer for the energy counter to power core.
// Depends on ectp_pkg for the command and status structs.

module ectp_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  ectp_pkg::dp_status_t   status,
  output ectp_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_DELTA,
    S_RD_MUL,
    S_RD_CHECK,
    S_RD_DIV,
    S_FINISH,
    S_RN_MUL,
    S_RN_STORE
  } state_t;

  state_t                        state_r, state_nxt;
  logic [ectp_pkg::CNT_W-1:0]    div_cnt_r, div_cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RD_DELTA;
        end
      end
      S_RD_DELTA: begin
        if (status.is_reading) begin
          cmd.rd_delta = 1'b1;
          state_nxt    = S_RD_MUL;
        end else begin
          cmd.rn_mul = 1'b1;
          state_nxt  = S_RN_STORE;
        end
      end
      S_RD_MUL: begin
        cmd.rd_mul = 1'b1;
        state_nxt  = S_RD_CHECK;
      end
      S_RD_CHECK: begin
        cmd.rd_check = 1'b1;
        div_cnt_nxt  = '0;
        state_nxt    = status.pass ? S_RD_DIV : S_FINISH;
      end
      S_RD_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + 1'b1;
        if (div_cnt_r == ectp_pkg::CNT_W'(ectp_pkg::QUO_W - 1)) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the result register is free
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_RN_MUL: begin
        cmd.rn_mul = 1'b1;
        state_nxt  = S_RN_STORE;
      end
      S_RN_STORE: begin
        cmd.rn_store = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

endmodule

// File: rtl/ectp_dp.sv
// Datapath of the energy counter to power core: configuration, timestamp and
// counter state, scaling multipliers, serial divider and result register.
// Depends on ectp_pkg for constants and the command and status structs.

module ectp_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ectp_pkg::ctrl_cmd_t    cmd,
  output ectp_pkg::dp_status_t   status,
  input  logic                   in_command,
  input  logic [31:0]            in_time_sec,
  input  logic [19:0]            in_time_usec,
  input  logic                   in_domain,
  input  logic [2:0]             in_socket,
  input  logic [31:0]            in_counter,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_domain,
  output logic [2:0]             out_socket,
  output logic [19:0]            out_power_mw,
  output logic [1:0]             out_status
);

  // Configuration
  logic [4:0]   exp_r;
  logic         core_en_r;
  logic         mem_en_r;

  // Captured word
  logic         cmd_r;
  logic [31:0]  sec_r;
  logic [19:0]  usec_r;
  logic         dom_r;
  logic [2:0]   sock_r;
  logic [31:0]  cnt_r;

  // Round state
  logic [31:0]  prev_sec_r;
  logic [19:0]  prev_usec_r;
  logic [31:0]  interval_r;
  logic [1:0]   round_r;
  logic [51:0]  rn_prod_r;
  logic [31:0]  rn_upart_r;

  // Reading state
  logic [31:0]  prev_cnt_r [ectp_pkg::TABLE_DEPTH];
  logic [31:0]  delta_r;
  logic         live_r;
  logic [41:0]  prod_lim_r;
  logic [61:0]  prod_big_r;
  logic [63:0]  limit_r;
  logic         pass_r;
  logic [31:0]  rem_r;
  logic [ectp_pkg::QUO_W-1:0] low_r;
  logic [ectp_pkg::QUO_W-1:0] quo_r;

  // Result register
  logic         out_valid_r;
  logic         out_dom_r;
  logic [2:0]   out_sock_r;
  logic [19:0]  out_pow_r;
  logic [1:0]   out_st_r;

  // Combinational terms
  logic                      sock_ok;
  logic                      dom_en;
  logic                      live;
  logic [ectp_pkg::IDX_W-1:0] idx;
  logic [31:0]               delta;
  logic                      borrow;
  logic [31:0]               sec_diff;
  logic [31:0]               upart;
  logic [52:0]               total;
  logic [31:0]               interval_nxt;
  logic                      warm;
  logic                      pass;
  logic [61:0]               scaled;
  logic [32:0]               trial;
  logic [32:0]               div_sub;
  logic                      div_ge;
  logic [1:0]                st_nxt;

  assign cfg_ready = 1'b1;

  // Table index and liveness of a reading
  assign sock_ok = (32'(sock_r) < 32'(ectp_pkg::SOCKETS));
  assign dom_en  = dom_r ? mem_en_r : core_en_r;
  assign live    = sock_ok && dom_en;
  assign idx     = dom_r ? (ectp_pkg::IDX_W'(ectp_pkg::SOCKETS) + ectp_pkg::IDX_W'(sock_r))
                         : ectp_pkg::IDX_W'(sock_r);
  assign delta   = cnt_r - prev_cnt_r[idx];

  // Elapsed microseconds with a one-second borrow
  assign borrow   = (usec_r < prev_usec_r);
  assign sec_diff = sec_r - prev_sec_r - {31'd0, borrow};
  assign upart    = borrow ? (32'(usec_r) + 32'(ectp_pkg::USEC_PER_SEC) - 32'(prev_usec_r))
                           : 32'(usec_r - prev_usec_r);
  assign total    = 53'(rn_prod_r) + 53'(rn_upart_r);

  // Saturate past 32 bits, force zero to one
  always_comb begin
    if (total[52:32] != '0) begin
      interval_nxt = 32'hFFFF_FFFF;
    end else if (total[31:0] == 32'd0) begin
      interval_nxt = 32'd1;
    end else begin
      interval_nxt = total[31:0];
    end
  end

  // Limit test and divider dividend
  assign warm   = !round_r[1];
  assign pass   = live_r && (delta_r != 32'd0) && !warm && (64'(prod_lim_r) <= limit_r);
  assign scaled = prod_big_r >> exp_r;

  // One restoring division step
  assign trial   = {rem_r, low_r[ectp_pkg::QUO_W-1]};
  assign div_sub = trial - {1'b0, interval_r};
  assign div_ge  = (trial >= {1'b0, interval_r});

  // Result status
  always_comb begin
    if (warm) begin
      st_nxt = ectp_pkg::ST_WARM;
    end else if (pass_r) begin
      st_nxt = ectp_pkg::ST_VALID;
    end else begin
      st_nxt = ectp_pkg::ST_INVALID;
    end
  end

  assign status.is_reading = (cmd_r == ectp_pkg::CMD_READING);
  assign status.pass       = pass;
  assign status.out_busy   = out_valid_r && !out_ready;

  // Control state: configuration, round state, table, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r       <= ectp_pkg::UNIT_EXP_RST;
      core_en_r   <= 1'b1;
      mem_en_r    <= 1'b1;
      prev_sec_r  <= '0;
      prev_usec_r <= '0;
      interval_r  <= 32'd1;
      round_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ectp_pkg::TABLE_DEPTH; i++) begin
        prev_cnt_r[i] <= '0;
      end
    end else begin
      // write a configuration word
      if (cfg_valid) begin
        unique case (cfg_index)
          ectp_pkg::REG_UNIT_EXP: exp_r     <= cfg_data[4:0];
          ectp_pkg::REG_CORE_EN:  core_en_r <= cfg_data[0];
          ectp_pkg::REG_MEM_EN:   mem_en_r  <= cfg_data[0];
          default: ;
        endcase
      end
      // store the new interval and timestamp
      if (cmd.rn_store) begin
        interval_r  <= interval_nxt;
        prev_sec_r  <= sec_r;
        prev_usec_r <= usec_r;
        if (core_en_r && (round_r != 2'd3)) begin
          round_r <= round_r + 2'd1;
        end
      end
      // advance the previous count of a live reading
      if (cmd.rd_delta && live) begin
        prev_cnt_r[idx] <= cnt_r;
      end
      // result valid: set on finish, drop when taken
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_command;
      sec_r  <= in_time_sec;
      usec_r <= in_time_usec;
      dom_r  <= in_domain;
      sock_r <= in_socket;
      cnt_r  <= in_counter;
    end
    if (cmd.rn_mul) begin
      rn_prod_r  <= 52'(sec_diff) * 52'(ectp_pkg::USEC_PER_SEC);
      rn_upart_r <= upart;
    end
    if (cmd.rd_delta) begin
      delta_r <= delta;
      live_r  <= live;
    end
    if (cmd.rd_mul) begin
      prod_lim_r <= 42'(delta_r) * 42'(ectp_pkg::LIMIT_SCALE);
      prod_big_r <= 62'(delta_r) * 62'(ectp_pkg::MW_SCALE);
      limit_r    <= 64'(interval_r) << exp_r;
    end
    if (cmd.rd_check) begin
      pass_r <= pass;
      rem_r  <= scaled[ectp_pkg::QUO_W+31:ectp_pkg::QUO_W];
      low_r  <= scaled[ectp_pkg::QUO_W-1:0];
      quo_r  <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= div_ge ? div_sub[31:0] : trial[31:0];
      low_r <= {low_r[ectp_pkg::QUO_W-2:0], 1'b0};
      quo_r <= {quo_r[ectp_pkg::QUO_W-2:0], div_ge};
    end
    if (cmd.finish) begin
      out_dom_r  <= dom_r;
      out_sock_r <= sock_r;
      out_st_r   <= st_nxt;
      out_pow_r  <= (!warm && pass_r) ? quo_r : '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_domain   = out_dom_r;
  assign out_socket   = out_sock_r;
  assign out_power_mw = out_pow_r;
  assign out_status   = out_st_r;

endmodule

// File: test/tb_top.sv
// Testbench for energy_counter_to_power_core: directed and random words with a scoreboard.
// Depends on ectp_pkg and the core's RTL; the scoreboard class predicts every result word.
`timescale 1ns / 1ps

import ectp_pkg::*;

typedef struct packed {
  logic        domain;
  logic [2:0]  socket;
  logic [19:0] power_mw;
  logic [1:0]  status;
} power_word_t;

// Predict power words from accepted input words and match them against the core
class power_scoreboard;
  logic [31:0] prev_count [TABLE_DEPTH];
  logic [31:0] last_sec;
  logic [19:0] last_usec;
  logic [31:0] interval_us;
  logic [1:0]  rounds;
  logic [4:0]  unit_exp;
  logic        core_en;
  logic        mem_en;
  power_word_t power_due [$];
  int          errors;

  function new();
    foreach (prev_count[i]) prev_count[i] = '0;
    last_sec    = '0;
    last_usec   = '0;
    interval_us = 32'd1;
    rounds      = '0;
    unit_exp    = UNIT_EXP_RST;
    core_en     = 1'b1;
    mem_en      = 1'b1;
    errors      = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [31:0] data);
    case (idx)
      REG_UNIT_EXP: unit_exp = data[4:0];
      REG_CORE_EN:  core_en  = data[0];
      REG_MEM_EN:   mem_en   = data[0];
      default: ;
    endcase
  endfunction

  function int pending();
    return power_due.size();
  endfunction

  // Advance the round on a round-start word, else queue the power word of a reading
  function void take_input_word(logic cmd, logic [31:0] sec, logic [19:0] usec,
                                logic dom, logic [2:0] sock, logic [31:0] cnt);
    logic [31:0] sec_diff;
    logic [31:0] usec_diff;
    logic [63:0] span;
    logic [63:0] delta;
    logic [63:0] limit;
    logic [63:0] scaled;
    logic        enabled;
    int          slot;
    power_word_t res;
    if (cmd == CMD_ROUND) begin
      // borrow one second when the microseconds went backwards
      if (usec >= last_usec) begin
        sec_diff  = sec - last_sec;
        usec_diff = {12'd0, usec} - {12'd0, last_usec};
      end else begin
        sec_diff  = sec - last_sec - 32'd1;
        usec_diff = {12'd0, usec} + {12'd0, USEC_PER_SEC} - {12'd0, last_usec};
      end
      span = {32'd0, sec_diff} * {44'd0, USEC_PER_SEC} + {32'd0, usec_diff};
      if (span > 64'h0000_0000_FFFF_FFFF) span = 64'h0000_0000_FFFF_FFFF;
      if (span == 64'd0) span = 64'd1;
      interval_us = span[31:0];
      last_sec    = sec;
      last_usec   = usec;
      if (core_en && rounds != 2'd3) rounds = rounds + 2'd1;
      return;
    end
    enabled = dom ? mem_en : core_en;
    res = power_word_t'({dom, sock, 20'd0, ST_INVALID});
    if (int'(sock) < SOCKETS && enabled) begin
      slot  = int'(dom) * SOCKETS + int'(sock);
      delta = {32'd0, cnt - prev_count[slot]};
      prev_count[slot] = cnt;
      if (delta != 64'd0) begin
        // limit test is exact, before the truncating divide
        limit = {32'd0, interval_us} << unit_exp;
        if (delta * {54'd0, LIMIT_SCALE} <= limit) begin
          scaled       = (delta * {34'd0, MW_SCALE}) >> unit_exp;
          res.power_mw = 20'(scaled / {32'd0, interval_us});
          res.status   = ST_VALID;
        end
      end
    end
    if (rounds <= 2'd1) begin
      res.status   = ST_WARM;
      res.power_mw = '0;
    end
    if (res.status != ST_VALID) res.power_mw = '0;
    power_due.push_back(res);
  endfunction

  function void check_result_word(power_word_t got);
    power_word_t want;
    if (power_due.size() == 0) begin
      $display("%0t: result word with nothing expected: domain %0d socket %0d power %0d status %0d",
               $time, got.domain, got.socket, got.power_mw, got.status);
      errors++;
      return;
    end
    want = power_due.pop_front();
    if (got.domain !== want.domain) begin
      $display("%0t: domain mismatch: expected %0d actual %0d", $time, want.domain, got.domain);
      errors++;
    end
    if (got.socket !== want.socket) begin
      $display("%0t: socket mismatch: expected %0d actual %0d", $time, want.socket, got.socket);
      errors++;
    end
    if (got.power_mw !== want.power_mw) begin
      $display("%0t: power_mw mismatch: expected %0d actual %0d",
               $time, want.power_mw, got.power_mw);
      errors++;
    end
    if (got.status !== want.status) begin
      $display("%0t: status mismatch: expected %0d actual %0d", $time, want.status, got.status);
      errors++;
    end
  endfunction
endclass

module tb_top;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int ITEMS_PER_PHASE = 121;
  localparam int PHASES          = 12;
  localparam int SETTLE_CYCLES   = 40;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_command;
  logic [31:0] in_time_sec;
  logic [19:0] in_time_usec;
  logic        in_domain;
  logic [2:0]  in_socket;
  logic [31:0] in_counter;
  logic        out_valid;
  logic        out_ready;
  logic        out_domain;
  logic [2:0]  out_socket;
  logic [19:0] out_power_mw;
  logic [1:0]  out_status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  power_scoreboard sb = new();

  // Stimulus-side shadow used only to aim counter deltas and timestamps
  logic [31:0] gen_cnt [TABLE_DEPTH];
  logic [31:0] gen_sec;
  logic [19:0] gen_usec;
  logic [31:0] gen_interval;
  logic [4:0]  cur_exp;
  logic        cur_core;
  logic        cur_mem;
  bit          tx_gaps;
  bit          rx_stalls;
  int          rx_hold;

  energy_counter_to_power_core u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_time_sec  (in_time_sec),
    .in_time_usec (in_time_usec),
    .in_domain    (in_domain),
    .in_socket    (in_socket),
    .in_counter   (in_counter),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_domain   (out_domain),
    .out_socket   (out_socket),
    .out_power_mw (out_power_mw),
    .out_status   (out_status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Watch all three handshakes on pre-edge values
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.take_input_word(in_command, in_time_sec, in_time_usec, in_domain, in_socket, in_counter);
    if (rst_n && out_valid && out_ready)
      sb.check_result_word(power_word_t'({out_domain, out_socket, out_power_mw, out_status}));
    if (rst_n && cfg_valid && cfg_ready)
      sb.write_reg(cfg_index, cfg_data);
  end

  // Offer one input word after a random gap and hold it until taken
  task automatic send_word(logic cmd, logic [31:0] sec, logic [19:0] usec,
                           logic dom, logic [2:0] sock, logic [31:0] cnt);
    int gap;
    gap = tx_gaps ? $urandom_range(7, 0) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_time_sec  <= sec;
    in_time_usec <= usec;
    in_domain    <= dom;
    in_socket    <= sock;
    in_counter   <= cnt;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // Unused fields carry random filler
  task automatic send_round(logic [31:0] sec, logic [19:0] usec);
    send_word(CMD_ROUND, sec, usec, 1'($urandom), 3'($urandom), $urandom);
    gen_sec  = sec;
    gen_usec = usec;
  endtask

  task automatic send_reading(logic dom, logic [2:0] sock, logic [31:0] cnt);
    send_word(CMD_READING, $urandom, 20'($urandom), dom, sock, cnt);
    if (dom ? cur_mem : cur_core) gen_cnt[int'(dom) * SOCKETS + int'(sock)] = cnt;
  endtask

  // Drop valid and wait until every expected word has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg_word(logic [1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
  endtask

  // Write every register once the core has gone idle; upper bits get noise
  task automatic set_config(logic [4:0] unit_exp_val, logic core, logic mem);
    logic [31:0] data;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    data = $urandom;
    data[4:0] = unit_exp_val;
    write_reg_word(REG_UNIT_EXP, data);
    data = $urandom;
    data[0] = core;
    write_reg_word(REG_CORE_EN, data);
    data = $urandom;
    data[0] = mem;
    write_reg_word(REG_MEM_EN, data);
    write_reg_word(REG_SPARE, $urandom);
    cfg_valid <= 1'b0;
    cur_exp  = unit_exp_val;
    cur_core = core;
    cur_mem  = mem;
  endtask

  // Receiver: random stalls per word, plus one long hold-off on request
  initial begin : receiver
    int stall;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end else if (rx_stalls) begin
        stall = $urandom_range(7, 0);
      end else begin
        stall = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin : stimulus
    int          n_items;
    int          n_reads;
    int          kind;
    int          slot;
    logic [63:0] tot;
    logic [63:0] lim;
    logic [31:0] max_d;
    logic [31:0] delta;
    logic [31:0] span_us;
    logic [31:0] t_sec;
    logic [19:0] t_usec;
    logic        dom;
    logic [2:0]  sock;

    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_command   <= CMD_ROUND;
    in_time_sec  <= '0;
    in_time_usec <= '0;
    in_domain    <= 1'b0;
    in_socket    <= '0;
    in_counter   <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_UNIT_EXP;
    cfg_data     <= '0;
    foreach (gen_cnt[i]) gen_cnt[i] = '0;
    gen_sec      = '0;
    gen_usec     = '0;
    gen_interval = 32'd1;
    cur_exp      = UNIT_EXP_RST;
    cur_core     = 1'b1;
    cur_mem      = 1'b1;
    tx_gaps      = 1'b1;
    rx_stalls    = 1'b1;
    rx_hold      = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Core disabled: the round count must not advance
    set_config(5'd16, 1'b0, 1'b1);
    send_round(32'd5, 20'd0);
    send_reading(1'b1, 3'd2, 32'd1234);
    set_config(5'd16, 1'b1, 1'b1);

    // Warm-up, then valid, zero delta, exact limit, over limit and counter wrap
    send_reading(1'b0, 3'd0, 32'd100);
    send_round(32'd0, 20'd0);
    send_reading(1'b1, 3'd7, 32'd5000);
    send_round(32'd1, 20'd0);
    send_reading(1'b0, 3'd0, 32'd1000100);
    send_reading(1'b0, 3'd0, 32'd1000100);
    send_reading(1'b1, 3'd7, 32'd65541000);
    send_reading(1'b1, 3'd7, 32'd131077001);
    send_reading(1'b0, 3'd1, 32'hFFFF_FFFF);
    send_reading(1'b0, 3'd1, 32'd5);
    // Microsecond borrow, zero interval, saturation, microseconds out of range
    send_round(32'd1, 20'd999999);
    send_round(32'd3, 20'd5);
    send_round(32'd3, 20'd5);
    send_reading(1'b0, 3'd2, 32'd1);
    send_round(32'hFFFF_FFFF, 20'd999999);
    send_reading(1'b1, 3'd3, 32'hFFFF_FFFF);
    send_round(32'd0, 20'hFFFFF);
    send_round(32'd0, 20'd0);
    send_round(32'd0, 20'd1000);
    gen_interval = 32'd1000;
    send_reading(1'b0, 3'd4, $urandom);

    // Random phases, each with its own register setting and idling mode
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_config(5'd16, 1'b1, 1'b1);
        1: set_config(5'd1, 1'b1, 1'b1);
        2: set_config(5'd31, 1'b1, 1'b1);
        3: set_config(5'd0, 1'b1, 1'b1);
        4: set_config(5'($urandom_range(31, 1)), 1'b0, 1'b1);
        5: set_config(5'($urandom_range(31, 1)), 1'b1, 1'b0);
        6: set_config(5'($urandom_range(31, 1)), 1'b0, 1'b0);
        default: set_config(5'($urandom), $urandom_range(4, 0) != 0, $urandom_range(4, 0) != 0);
      endcase
      tx_gaps   = $urandom_range(3, 0) != 0;
      rx_stalls = $urandom_range(3, 0) != 0;
      n_items   = 0;
      while (n_items < ITEMS_PER_PHASE) begin
        if (p == 3 && n_items >= 40 && n_items < 50) rx_hold = 400;
        if (p == 5 && n_items >= 60 && n_items < 70) drain_results();
        kind = $urandom_range(99, 0);
        if (kind < 8) begin
          // noise: any field value, either command
          if ($urandom_range(1, 0) == 0) begin
            send_round($urandom, 20'($urandom));
            gen_interval = $urandom;
          end else begin
            send_reading(1'($urandom), 3'($urandom), $urandom);
          end
          n_items++;
          continue;
        end
        if (kind >= 15) begin
          // well-formed round start with a plausible interval
          kind = $urandom_range(9, 0);
          if (kind == 9) begin
            t_sec        = gen_sec + $urandom;
            t_usec       = 20'($urandom_range(999999, 0));
            gen_interval = 32'hFFFF_FFFF;
          end else begin
            span_us = (kind == 7) ? 32'd0 :
                      (kind == 8) ? $urandom_range(999, 1) : $urandom_range(3000000, 1000);
            tot          = {44'd0, gen_usec} + {32'd0, span_us};
            t_usec       = 20'(tot % 64'd1000000);
            t_sec        = gen_sec + 32'(tot / 64'd1000000);
            gen_interval = (span_us == 0) ? 32'd1 : span_us;
          end
          send_round(t_sec, t_usec);
          n_items++;
        end
        // readings aimed around the power limit of the current interval
        n_reads = $urandom_range(10, 1);
        for (int r = 0; r < n_reads; r++) begin
          dom   = 1'($urandom);
          sock  = 3'($urandom);
          slot  = int'(dom) * SOCKETS + int'(sock);
          lim   = ({32'd0, gen_interval} << cur_exp) / 64'd1000;
          max_d = (lim > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : lim[31:0];
          kind  = $urandom_range(9, 0);
          case (kind)
            5:       delta = $urandom_range(1000, 1);
            6:       delta = 32'd0;
            7:       delta = max_d + 32'($urandom_range(1, 0));
            8:       delta = $urandom;
            9:       delta = max_d + $urandom_range(1000, 1);
            default: delta = (max_d == 0) ? 32'd1 : $urandom_range(max_d, 1);
          endcase
          send_reading(dom, sock, gen_cnt[slot] + delta);
          n_items++;
        end
      end
    end

    // Wait out every result and the tail of the last word
    drain_results();
    repeat (60) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected result words never arrived", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Timeout guard
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
